// ===== hdl/rkx_pkg.sv =====
`default_nettype none

package rkx_pkg;

   // Fixed widths of the request, response and register payloads.
   localparam int unsigned OPCODE_W    = 2;
   localparam int unsigned DATA_W      = 8;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned KEY_WORDS   = 4;
   localparam int unsigned BASE_BYTES  = 32;
   localparam int unsigned BASE_W      = BASE_BYTES * DATA_W;

   typedef enum logic [OPCODE_W-1:0] {
      OP_MSG     = 2'd0,
      OP_CHUNK   = 2'd1,
      OP_RESTORE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_WORD_0 = 2'd0,
      CSR_KEY_WORD_1 = 2'd1,
      CSR_KEY_WORD_2 = 2'd2,
      CSR_KEY_WORD_3 = 2'd3
   } csr_index_type;

   // Commands from the sequencer to the key bank.
   typedef struct packed {
      logic load;        // restore the base key and clear the round count
      logic roll;        // roll the key at this edge
      logic use_rolled;  // the byte is ciphered with the rolled key
   } key_cmd_type;

   // One key byte after a roll: mask with (round*31 + index*17), rotate left.
   function automatic logic [DATA_W-1:0] roll_byte(input logic [DATA_W-1:0] value,
                                                   input logic [DATA_W-1:0] round,
                                                   input logic [DATA_W-1:0] index);
      logic [DATA_W-1:0] mask;
      logic [DATA_W-1:0] mixed;
      mask  = (round << 5) - round + (index << 4) + index;
      mixed = value ^ mask;
      return {mixed[DATA_W-2:0], mixed[DATA_W-1]};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/rkx_channels.sv =====
`default_nettype none

interface rkx_req_if;
   logic                           valid;
   logic                           ready;
   logic [rkx_pkg::OPCODE_W-1:0]   opcode;
   logic [rkx_pkg::DATA_W-1:0]     byte_in;
   logic                           is_last;

   modport source (output valid, output opcode, output byte_in, output is_last, input ready);
   modport sink   (input valid, input opcode, input byte_in, input is_last, output ready);
endinterface

interface rkx_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rkx_pkg::DATA_W-1:0]     byte_out;
   logic                           out_last;

   modport source (output valid, output byte_out, output out_last, input ready);
   modport sink   (input valid, input byte_out, input out_last, output ready);
endinterface

interface rkx_csr_if;
   logic                              valid;
   logic                              ready;
   logic [rkx_pkg::CSR_INDEX_W-1:0]   index;
   logic [rkx_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/rolling_key_xor_stream_cipher.sv =====
// Channel   Direction  Payload                              Handshake
// req_chan  in         opcode[1:0], byte_in[7:0], is_last   valid/ready
// rsp_chan  out        byte_out[7:0], out_last              valid/ready
// csr_chan  in         index[1:0], data[63:0]               valid/ready, always ready
//
// One request per cycle: a byte request is ciphered in the cycle it is accepted and its
// response is registered, so it appears in the cycle after. The key roll updates all key
// bytes in parallel, so no request ever waits on it. Request ready drops only while a
// response is held and the response side stalls. Reset is synchronous and clears the
// base key, the current key, the round count and the chunk and key positions.
`default_nettype none

module rolling_key_xor_stream_cipher #(
   parameter int unsigned KEY_BYTES   = 32,
   parameter int unsigned CHUNK_BYTES = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   rkx_req_if.sink   req_chan,
   rkx_rsp_if.source rsp_chan,
   rkx_csr_if.sink   csr_chan
);
   import rkx_pkg::*;

   localparam int unsigned KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

   logic [CSR_DATA_W-1:0] key_word_ff [KEY_WORDS];
   logic [BASE_W-1:0]     base_key;
   key_cmd_type           cmd;
   logic [KIDX_W-1:0]     key_index;
   logic [DATA_W-1:0]     key_byte;
   logic                  fire;
   logic                  emit;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     byte_out_ff;
   logic                  out_last_ff;

   // Base key registers.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_word_ff[i] <= '0;
         end
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_KEY_WORD_0: key_word_ff[0] <= csr_chan.data;
            CSR_KEY_WORD_1: key_word_ff[1] <= csr_chan.data;
            CSR_KEY_WORD_2: key_word_ff[2] <= csr_chan.data;
            CSR_KEY_WORD_3: key_word_ff[3] <= csr_chan.data;
            default: ;
         endcase
      end
   end

   assign base_key = {key_word_ff[3], key_word_ff[2], key_word_ff[1], key_word_ff[0]};

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_chan.valid && req_chan.ready;

   rkx_sequencer #(
      .KEY_BYTES   (KEY_BYTES),
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .opcode    (req_chan.opcode),
      .is_last   (req_chan.is_last),
      .cmd       (cmd),
      .key_index (key_index),
      .emit      (emit)
   );

   rkx_key_bank #(
      .KEY_BYTES (KEY_BYTES)
   ) u_key_bank (
      .clock     (clock),
      .reset     (reset),
      .base_key  (base_key),
      .cmd       (cmd),
      .key_index (key_index),
      .key_byte  (key_byte)
   );

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_out_ff <= req_chan.byte_in ^ key_byte;
         out_last_ff <= req_chan.is_last;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.byte_out = byte_out_ff;
   assign rsp_chan.out_last = out_last_ff;

endmodule

`default_nettype wire

// ===== hdl/rkx_key_bank.sv =====
`default_nettype none

module rkx_key_bank #(
   parameter int unsigned KEY_BYTES = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [rkx_pkg::BASE_W-1:0]    base_key,
   input  wire rkx_pkg::key_cmd_type          cmd,
   input  wire logic [((KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1)-1:0] key_index,
   output logic      [rkx_pkg::DATA_W-1:0]    key_byte
);
   import rkx_pkg::*;

   logic [DATA_W-1:0] key_ff    [KEY_BYTES];
   logic [DATA_W-1:0] key_in    [KEY_BYTES];
   logic [DATA_W-1:0] rolled    [KEY_BYTES];
   logic [DATA_W-1:0] round_ff;
   logic [DATA_W-1:0] round_in;
   logic [DATA_W-1:0] round_next;

   assign round_next = round_ff + DATA_W'(1);

   // Every key byte rolls in parallel with the incremented round count.
   for (genvar i = 0; i < KEY_BYTES; i++) begin : g_roll
      assign rolled[i] = roll_byte(key_ff[i], round_next, DATA_W'(i));
   end

   always_comb begin
      round_in = round_ff;
      for (int i = 0; i < KEY_BYTES; i++) begin
         key_in[i] = key_ff[i];
      end
      if (cmd.load) begin
         round_in = '0;
         for (int i = 0; i < KEY_BYTES; i++) begin
            key_in[i] = base_key[i*DATA_W +: DATA_W];
         end
      end else if (cmd.roll) begin
         round_in = round_next;
         for (int i = 0; i < KEY_BYTES; i++) begin
            key_in[i] = rolled[i];
         end
      end
   end

   assign key_byte = cmd.use_rolled ? rolled[key_index] : key_ff[key_index];

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= '0;
         for (int i = 0; i < KEY_BYTES; i++) begin
            key_ff[i] <= '0;
         end
      end else begin
         round_ff <= round_in;
         for (int i = 0; i < KEY_BYTES; i++) begin
            key_ff[i] <= key_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rkx_sequencer.sv =====
`default_nettype none

module rkx_sequencer #(
   parameter int unsigned KEY_BYTES   = 32,
   parameter int unsigned CHUNK_BYTES = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           fire,
   input  wire logic [rkx_pkg::OPCODE_W-1:0]   opcode,
   input  wire logic                           is_last,
   output rkx_pkg::key_cmd_type                cmd,
   output logic [((KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1)-1:0] key_index,
   output logic                                emit
);
   import rkx_pkg::*;

   localparam int unsigned KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam int unsigned CP_W   = $clog2(CHUNK_BYTES + 1);

   op_type            op;
   logic [CP_W-1:0]   cp_ff, cp_in, cp_eff, cp_next;
   logic [KIDX_W-1:0] kp_ff, kp_in, kp_eff, kp_next;
   logic              in_msg_ff, in_msg_in;
   logic              byte_op;
   logic              pre_roll;

   assign op      = op_type'(opcode);
   assign byte_op = (op == OP_MSG) || (op == OP_CHUNK);
   assign emit    = fire && byte_op;

   // A message byte that starts a later chunk rolls the key first and then
   // uses key byte zero of the rolled key.
   assign pre_roll = (op == OP_MSG) && in_msg_ff && (cp_ff == CP_W'(CHUNK_BYTES));
   assign cp_eff   = pre_roll ? '0 : cp_ff;
   assign kp_eff   = pre_roll ? '0 : kp_ff;
   assign kp_next  = (kp_eff == KIDX_W'(KEY_BYTES - 1)) ? '0 : kp_eff + KIDX_W'(1);
   assign cp_next  = ((op == OP_MSG) && (cp_eff < CP_W'(CHUNK_BYTES))) ?
                     cp_eff + CP_W'(1) : cp_eff;
   assign key_index = kp_eff;

   always_comb begin
      cmd.load       = fire && (op == OP_RESTORE);
      cmd.roll       = emit && (pre_roll || ((op == OP_CHUNK) && is_last));
      cmd.use_rolled = pre_roll;
      cp_in          = cp_ff;
      kp_in          = kp_ff;
      in_msg_in      = in_msg_ff;
      if (cmd.load || (emit && is_last)) begin
         cp_in     = '0;
         kp_in     = '0;
         in_msg_in = 1'b0;
      end else if (emit) begin
         cp_in     = cp_next;
         kp_in     = kp_next;
         in_msg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_ff     <= '0;
         kp_ff     <= '0;
         in_msg_ff <= 1'b0;
      end else begin
         cp_ff     <= cp_in;
         kp_ff     <= kp_in;
         in_msg_ff <= in_msg_in;
      end
   end

   a_kp_range: assert property (@(posedge clock) disable iff (reset)
      kp_ff <= KIDX_W'(KEY_BYTES - 1))
      else $error("key position beyond key length");

   a_cp_range: assert property (@(posedge clock) disable iff (reset)
      cp_ff <= CP_W'(CHUNK_BYTES))
      else $error("chunk position beyond chunk length");

   a_closed_call: assert property (@(posedge clock) disable iff (reset)
      !in_msg_ff |-> (cp_ff == '0) && (kp_ff == '0))
      else $error("positions not cleared while no call is open");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (emit && is_last) |=> !in_msg_ff && (kp_ff == '0))
      else $error("call still open after its last byte");

endmodule

`default_nettype wire
